>>> design/swm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the sliding window maximum unit.
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int WLEN_W       = 7;
   localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic REG_WINDOW_LEN = 1'b0;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      logic       advance;
      logic       start;
      sample_type sample;
   } swm_bcast_type;

endpackage

>>> design/swm_cell.sv
`timescale 1ns / 1ps
// One cell of the running maximum chain.
module swm_cell
   import swm_pkg::*;
(
   input  logic          clock,
   input  swm_bcast_type bcast,
   input  sample_type    prev_max,
   output sample_type    cell_max
);

   sample_type max_ff;
   sample_type max_in;

   always_comb begin
      if (bcast.start) begin
         max_in = bcast.sample;
      end else if (prev_max > bcast.sample) begin
         max_in = prev_max;
      end else begin
         max_in = bcast.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.advance) begin
         max_ff <= max_in;
      end
   end

   assign cell_max = max_ff;

endmodule

>>> design/swm_csr.sv
`timescale 1ns / 1ps
// Configuration register block: window length register and its clamped value.
module swm_csr
   import swm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CNT_W-1:0]      win_eff
);

   logic [WLEN_W-1:0] wlen_ff;
   logic [WLEN_W-1:0] wlen_in;
   logic              hit;

   assign hit = (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LEN);

   always_comb begin
      wlen_in = wlen_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         wlen_in = csr_pwdata[WLEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_W'(1);
      end else begin
         wlen_ff <= wlen_in;
      end
   end

   always_comb begin
      if (wlen_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (int'(wlen_ff) > MAX_WINDOW) begin
         win_eff = CNT_W'(MAX_WINDOW);
      end else begin
         win_eff = CNT_W'(wlen_ff);
      end
   end

   assign csr_prdata = hit ? CSR_DATA_W'(wlen_ff) : '0;
   assign csr_pready = 1'b1;

endmodule

>>> design/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
// Sliding window maximum unit: one request per cycle unless req_stall is high; the result is registered.
// Each request carries a signed sample; once window_len samples have arrived since the last
// start request (or reset) the unit answers with the largest of the last window_len samples,
// otherwise the request produces no response. A row of cells keeps running maxima over the
// most recent samples (cell i holds the maximum of the last i+1 samples) and all cells advance
// together on every accepted request, so the unit sustains one request per clock unless req_stall
// is high; the result register frees as soon as the response side takes it. window_len is read
// at 0 (a value of 0 acts as 1, values above 64 act as 64) and takes effect on the next request.
module sliding_window_maximum_unit
   import swm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sample_type            req_sample,
   input  logic                  req_start_req,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sample_type            rsp_window_max,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] win_eff;
   swm_bcast_type    bcast;
   sample_type       cell_max [MAX_WINDOW];

   logic             req_accept;
   logic [CNT_W-1:0] seen_count_ff, seen_count_in, seen_base;
   logic [CNT_W-1:0] live_count_ff, live_count_in, live_base;
   logic             produce;
   logic [IDX_W-1:0] rd_index;
   sample_type       tap;
   sample_type       result;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_max_ff;

   swm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .win_eff     (win_eff)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign bcast.advance = req_accept;
   assign bcast.start   = req_start_req;
   assign bcast.sample  = req_sample;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            swm_cell u_cell (
               .clock    (clock),
               .bcast    (bcast),
               .prev_max (req_sample),
               .cell_max (cell_max[gi])
            );
         end else begin : g_body
            swm_cell u_cell (
               .clock    (clock),
               .bcast    (bcast),
               .prev_max (cell_max[gi-1]),
               .cell_max (cell_max[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      seen_base = req_start_req ? '0 : seen_count_ff;
      if (seen_base < win_eff) begin
         seen_count_in = seen_base + CNT_W'(1);
      end else begin
         seen_count_in = seen_base;
      end
      produce = (seen_count_in >= win_eff);

      live_base = req_start_req ? '0 : live_count_ff;
      if (live_base >= win_eff) begin
         live_count_in = win_eff;
      end else begin
         live_count_in = live_base + CNT_W'(1);
      end

      rd_index = IDX_W'(live_count_in - CNT_W'(2));
      tap      = cell_max[rd_index];
      if (live_count_in == CNT_W'(1)) begin
         result = req_sample;
      end else if (tap > req_sample) begin
         result = tap;
      end else begin
         result = req_sample;
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = produce;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            seen_count_ff <= seen_count_in;
            live_count_ff <= live_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && produce) begin
         rsp_max_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   a_start_live: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_start_req |=> live_count_ff == CNT_W'(1))
      else $error("start request did not restart the live window");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> live_count_ff <= $past(win_eff) && live_count_ff != '0)
      else $error("live window count out of range");

   a_rsp_gate: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff == (seen_count_ff >= $past(win_eff)))
      else $error("response valid does not follow the seen count");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window maximum unit with a deque-based predictor.
module tb
   import swm_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] WLEN_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_LEN);
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam int RANDOM_REQUESTS = 1080;

   typedef struct packed {
      sample_type  value;
      logic [15:0] pos;
   } candidate_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   sample_type            req_sample = '0;
   logic                  req_start_req = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   sample_type            rsp_window_max;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   candidate_type     cand_q[$];
   sample_type        expected_max_q[$];
   logic [WLEN_W-1:0] window_reg = WLEN_W'(1);
   logic [15:0]       next_pos = '0;
   int                seen_in_seq = 0;

   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int rx_wait = 0;
   int request_count = 0;
   int result_count = 0;
   int setting_count = 0;
   int error_count = 0;

   sliding_window_maximum_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) $display("mismatch: %s", msg);
   endtask

   function automatic int active_window();
      if (window_reg == 0) return 1;
      if (window_reg > MAX_WINDOW) return MAX_WINDOW;
      return int'(window_reg);
   endfunction

   function automatic void predict_window_max(input sample_type s, input logic st);
      int w;
      candidate_type cand;
      w = active_window();
      if (st) begin
         cand_q.delete();
         seen_in_seq = 0;
         next_pos = '0;
      end
      while (cand_q.size() > 0 && int'(16'(next_pos - cand_q[0].pos)) >= w)
         cand_q.delete(0);
      while (cand_q.size() > 0 && $signed(cand_q[cand_q.size()-1].value) < $signed(s))
         cand_q.delete(cand_q.size() - 1);
      if (cand_q.size() >= MAX_WINDOW) cand_q.delete(0);
      cand.value = s;
      cand.pos = next_pos;
      cand_q.insert(cand_q.size(), cand);
      next_pos = next_pos + 16'd1;
      if (seen_in_seq < w) seen_in_seq++;
      if (seen_in_seq >= w) expected_max_q.insert(expected_max_q.size(), cand_q[0].value);
   endfunction

   task automatic send_sample(input sample_type s, input logic st);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_start_req <= st;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_window_max(s, st);
      request_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_max_q.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= WLEN_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      window_reg = value[WLEN_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[WLEN_W-1:0] !== value[WLEN_W-1:0])
         report_mismatch($sformatf("window_len read %0d, wrote %0d",
                                   csr_prdata[WLEN_W-1:0], value[WLEN_W-1:0]));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      setting_count++;
   endtask

   always @(posedge clock) begin : result_check
      sample_type want;
      if (reset) begin
         rx_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_max_q.size() == 0) begin
               report_mismatch($sformatf("window_max %0d with no request pending",
                                         rsp_window_max));
            end else begin
               want = expected_max_q[0];
               expected_max_q.delete(0);
               if (rsp_window_max !== want)
                  report_mismatch($sformatf("window_max %0d, expected %0d",
                                            rsp_window_max, want));
            end
            rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_stall <= (rx_wait > 0);
      end
   end

   task automatic test_without_start();
      send_sample(32'sd5, 1'b0);
      send_sample(-32'sd3, 1'b0);
   endtask

   task automatic test_window_len_zero();
      write_window_len(32'd0);
      send_sample(32'sd9, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
   endtask

   task automatic test_sample_extremes();
      write_window_len(32'd3);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
   endtask

   task automatic test_equal_values();
      write_window_len(32'd2);
      send_sample(32'sd7, 1'b1);
      send_sample(32'sd7, 1'b0);
      send_sample(32'sd7, 1'b0);
      send_sample(32'sd3, 1'b0);
      send_sample(32'sd3, 1'b0);
   endtask

   task automatic test_window_change_midstream();
      write_window_len(32'd4);
      send_sample(32'sd1, 1'b1);
      send_sample(32'sd9, 1'b0);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd3, 1'b0);
      send_sample(32'sd4, 1'b0);
      write_window_len(32'd2);
      send_sample(32'sd1, 1'b0);
      write_window_len(32'd6);
      send_sample(32'sd2, 1'b0);
      send_sample(32'sd0, 1'b0);
   endtask

   task automatic test_random_streams();
      int sent;
      int phase;
      int pick;
      int seq_len;
      int flavor;
      logic [CSR_DATA_W-1:0] wl;
      sample_type base;
      sample_type s;
      logic st;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         pick = (phase < 4) ? phase : $urandom_range(4, 12);
         case (pick) inside
            0: wl = 32'd127;
            1: wl = 32'd0;
            2: wl = 32'd64;
            3: wl = 32'd1;
            4: wl = $urandom_range(65, 127);
            5, 6: wl = $urandom_range(1, 64);
            default: wl = $urandom_range(2, 8);
         endcase
         if ($urandom_range(0, 3) == 0) wl = wl | ($urandom & ~32'h7F);
         write_window_len(wl);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 4)) begin
            seq_len = $urandom_range(1, 2 * active_window() + 8);
            flavor = $urandom_range(0, 4);
            base = $urandom;
            for (int i = 0; i < seq_len && sent < RANDOM_REQUESTS; i++) begin
               case (flavor)
                  1: s = sample_type'($urandom_range(0, 8)) - sample_type'(4);
                  2: case ($urandom_range(0, 3))
                        0: s = SAMPLE_MIN;
                        1: s = SAMPLE_MAX;
                        2: s = -32'sd1;
                        default: s = '0;
                     endcase
                  3: s = base + sample_type'(i);
                  4: s = base - sample_type'(i);
                  default: s = $urandom;
               endcase
               st = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 49) == 0);
               send_sample(s, st);
               sent++;
            end
         end
         phase++;
      end
   endtask

   initial begin : stimulus
      int guard;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_without_start();
      test_window_len_zero();
      test_sample_extremes();
      test_equal_values();
      test_window_change_midstream();
      test_random_streams();
      req_valid <= 1'b0;
      guard = 0;
      while (expected_max_q.size() > 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (expected_max_q.size() > 0)
         report_mismatch($sformatf("%0d results never arrived", expected_max_q.size()));
      $display("Ran %0d requests and %0d window results over %0d window_len settings,",
               request_count, result_count, setting_count);
      $display("including out-of-range lengths, mid-sequence changes and random stalls.");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
